### rtl/atipd_pkg.sv
`timescale 1ns / 1ps

package atipd_pkg;

   // Line store geometry
   localparam int LINE_MAX = 64;
   localparam int ADDR_W   = $clog2(LINE_MAX);
   // Counts and lengths saturate at 127
   localparam int CNT_W    = 7;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Characters of interest
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam int PREFIX_LEN         = 4;

   // Frame kinds on the result channel
   typedef enum logic [1:0] {
      KIND_LINE  = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;       // input item taken this cycle
      logic rd_en;        // read line store into read register
      logic advance;      // step drain pointer, read the next entry
      logic load_byte;    // load output register from read register
      logic load_single;  // load output register with a byteless result
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit_bytes;   // current input item ends a frame with bytes
      logic emit_single;  // current input item ends in one byteless result
      logic out_free;     // output register can take a result
      logic last_byte;    // drain pointer is on the final byte
   } dp_stat_type;

   // Expected "+IPD" character at a 1-based position
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (pos)
         3'd1:    ch = 8'h2B;   // '+'
         3'd2:    ch = 8'h49;   // 'I'
         3'd3:    ch = 8'h50;   // 'P'
         3'd4:    ch = 8'h44;   // 'D'
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/atipd_chan_if.sv
`timescale 1ns / 1ps

// Received byte channel
interface atipd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface atipd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic [1:0] frame_kind;
   logic       last_of_frame;

   modport source (output valid, output out_byte, output has_byte, output frame_kind,
                   output last_of_frame, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input frame_kind,
                   input last_of_frame, output ready);
endinterface

### rtl/atipd_dp.sv
`timescale 1ns / 1ps

module atipd_dp import atipd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [7:0]  rx_byte,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [7:0]  out_byte,
   output logic        has_byte,
   output kind_type    frame_kind,
   output logic        last_of_frame
);

   // Line store and its registered read port
   logic [7:0] line_store [LINE_MAX];
   logic [7:0] rd_data_ff;

   // Parser state
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             prefix_ok_ff, prefix_ok_in;
   logic             frame_seen_ff, frame_seen_in;
   logic             len_known_ff, len_known_in;
   logic [CNT_W-1:0] prefix_len_ff, prefix_len_in;
   logic [CNT_W-1:0] len_acc_ff, len_acc_in;
   logic [CNT_W-1:0] frame_total_ff, frame_total_in;

   // Drain state
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] end_ff, end_in;
   kind_type         kind_ff, kind_in;
   logic [CNT_W-1:0] rd_addr;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       has_byte_ff;
   kind_type   frame_kind_ff;
   logic       last_ff;

   // Per-item parse results
   logic [CNT_W-1:0] cnt_nx;
   logic             is_nl, is_colon, is_digit;
   logic [10:0]      acc_wide;
   logic [CNT_W-1:0] acc_sat;
   logic [CNT_W:0]   tot_wide;
   logic [CNT_W-1:0] tot_sat;
   logic             ok_n, seen_n, known_n;
   logic [CNT_W-1:0] pl_n, acc_n, tot_n;
   logic [CNT_W-1:0] emit_from, emit_to;
   kind_type         emit_kind;
   logic             emit_bytes, emit_single, restart;

   // Byte classes and saturating arithmetic
   assign cnt_nx   = byte_count_ff + CNT_W'(1);
   assign is_nl    = (rx_byte == CHAR_NL);
   assign is_colon = (rx_byte == CHAR_COLON);
   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign acc_wide = ({4'b0, len_acc_ff} << 3) + ({4'b0, len_acc_ff} << 1)
                     + {7'b0, rx_byte[3:0]};
   assign acc_sat  = (acc_wide > {4'b0, CNT_MAX}) ? CNT_MAX : acc_wide[CNT_W-1:0];
   assign tot_wide = {1'b0, cnt_nx} + {1'b0, len_acc_ff};
   assign tot_sat  = tot_wide[CNT_W] ? CNT_MAX : tot_wide[CNT_W-1:0];

   // Parse one byte and decide whether it ends a frame
   always_comb begin
      ok_n        = prefix_ok_ff;
      seen_n      = frame_seen_ff;
      known_n     = len_known_ff;
      pl_n        = prefix_len_ff;
      acc_n       = len_acc_ff;
      tot_n       = frame_total_ff;
      emit_from   = '0;
      emit_to     = '0;
      emit_kind   = KIND_LINE;
      emit_bytes  = 1'b0;
      emit_single = 1'b0;
      if (!frame_seen_ff) begin
         if (is_nl) begin
            // plain line, newline included
            emit_bytes = 1'b1;
            emit_to    = cnt_nx;
         end else if (cnt_nx <= CNT_W'(PREFIX_LEN)) begin
            ok_n = prefix_ok_ff && (rx_byte == prefix_char(cnt_nx[2:0]));
            if ((cnt_nx == CNT_W'(PREFIX_LEN)) && ok_n) begin
               seen_n = 1'b1;
               acc_n  = '0;
            end
         end
      end else if (!len_known_ff) begin
         if (is_colon) begin
            pl_n    = cnt_nx;
            tot_n   = tot_sat;
            known_n = 1'b1;
         end else if (is_digit) begin
            acc_n = acc_sat;
         end else begin
            acc_n = '0;
         end
      end
      if (!emit_bytes) begin
         if (seen_n && known_n && (cnt_nx == tot_n)) begin
            emit_kind = KIND_DATA;
            emit_from = pl_n;
            emit_to   = tot_n;
            if (pl_n >= tot_n) begin
               emit_single = 1'b1;
            end else begin
               emit_bytes = 1'b1;
            end
         end else if (cnt_nx >= CNT_W'(LINE_MAX)) begin
            emit_kind   = KIND_ERROR;
            emit_single = 1'b1;
         end
      end
   end

   assign restart = emit_bytes || emit_single;

   // Next parser and drain state
   always_comb begin
      byte_count_in  = byte_count_ff;
      prefix_ok_in   = prefix_ok_ff;
      frame_seen_in  = frame_seen_ff;
      len_known_in   = len_known_ff;
      prefix_len_in  = prefix_len_ff;
      len_acc_in     = len_acc_ff;
      frame_total_in = frame_total_ff;
      rd_ptr_in      = rd_ptr_ff;
      end_in         = end_ff;
      kind_in        = kind_ff;
      if (cmd.accept) begin
         if (restart) begin
            byte_count_in  = '0;
            prefix_ok_in   = 1'b1;
            frame_seen_in  = 1'b0;
            len_known_in   = 1'b0;
            prefix_len_in  = '0;
            len_acc_in     = '0;
            frame_total_in = '0;
            rd_ptr_in      = emit_from;
            end_in         = emit_to;
            kind_in        = emit_kind;
         end else begin
            byte_count_in  = cnt_nx;
            prefix_ok_in   = ok_n;
            frame_seen_in  = seen_n;
            len_known_in   = known_n;
            prefix_len_in  = pl_n;
            len_acc_in     = acc_n;
            frame_total_in = tot_n;
         end
      end else if (cmd.advance) begin
         rd_ptr_in = rd_ptr_ff + CNT_W'(1);
      end
   end

   // Read the current entry, or the next one while stepping
   assign rd_addr = cmd.advance ? (rd_ptr_ff + CNT_W'(1)) : rd_ptr_ff;

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_byte || cmd.load_single) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         prefix_ok_ff   <= 1'b1;
         frame_seen_ff  <= 1'b0;
         len_known_ff   <= 1'b0;
         prefix_len_ff  <= '0;
         len_acc_ff     <= '0;
         frame_total_ff <= '0;
         rd_ptr_ff      <= '0;
         end_ff         <= '0;
         kind_ff        <= KIND_LINE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         prefix_ok_ff   <= prefix_ok_in;
         frame_seen_ff  <= frame_seen_in;
         len_known_ff   <= len_known_in;
         prefix_len_ff  <= prefix_len_in;
         len_acc_ff     <= len_acc_in;
         frame_total_ff <= frame_total_in;
         rd_ptr_ff      <= rd_ptr_in;
         end_ff         <= end_in;
         kind_ff        <= kind_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         line_store[byte_count_ff[ADDR_W-1:0]] <= rx_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= line_store[rd_addr[ADDR_W-1:0]];
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         out_byte_ff   <= rd_data_ff;
         has_byte_ff   <= 1'b1;
         frame_kind_ff <= kind_ff;
         last_ff       <= stat.last_byte;
      end else if (cmd.load_single) begin
         out_byte_ff   <= 8'h00;
         has_byte_ff   <= 1'b0;
         frame_kind_ff <= kind_ff;
         last_ff       <= 1'b1;
      end
   end

   assign stat.emit_bytes  = emit_bytes;
   assign stat.emit_single = emit_single;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign stat.last_byte   = ((rd_ptr_ff + CNT_W'(1)) == end_ff);

   assign rsp_valid     = rsp_valid_ff;
   assign out_byte      = out_byte_ff;
   assign has_byte      = has_byte_ff;
   assign frame_kind    = frame_kind_ff;
   assign last_of_frame = last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < CNT_W'(LINE_MAX))
      else $error("byte count past line store size");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && restart |=> byte_count_ff == '0)
      else $error("parser not restarted after frame end");

   a_byteless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !has_byte_ff |-> last_ff)
      else $error("byteless result not marked last");

   a_error_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (frame_kind_ff == KIND_ERROR) |-> !has_byte_ff)
      else $error("overflow result carries a byte");

   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_byte |-> rd_ptr_ff < end_ff)
      else $error("drain pointer past frame end");
`endif

endmodule

### rtl/atipd_ctrl.sv
`timescale 1ns / 1ps

module atipd_ctrl import atipd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_LOAD   = 4'b0100,
      S_SINGLE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Sequencing: take bytes, then drain a finished frame or give one byteless result
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && stat.emit_bytes) begin
               state_in = S_READ;
            end else if (req_valid && stat.emit_single) begin
               state_in = S_SINGLE;
            end
         end
         S_READ: begin
            // prime the read register with the first byte
            cmd.rd_en = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.load_byte = 1'b1;
               if (stat.last_byte) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.advance = 1'b1;
               end
            end
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               cmd.load_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/at_response_ipd_deframer_unit.sv
`timescale 1ns / 1ps
// Frame end: a byte that ends a frame primes the read register, then loads the
//   first result (an empty payload or an overflow error loads one byteless result).
// Throughput: one byte per cycle while no frame ends; a burst then drains the line store
//   at one result per cycle while the result channel is ready, bound by its single registered read port.
// Reset: synchronous, active high; parser restarts with an empty line store.

module at_response_ipd_deframer_unit import atipd_pkg::*; (
   input logic         clock,
   input logic         reset,
   atipd_req_if.sink   req_if,
   atipd_rsp_if.source rsp_if
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   kind_type    frame_kind;

   atipd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   atipd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .rx_byte       (req_if.rx_byte),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .out_byte      (rsp_if.out_byte),
      .has_byte      (rsp_if.has_byte),
      .frame_kind    (frame_kind),
      .last_of_frame (rsp_if.last_of_frame)
   );

   assign rsp_if.frame_kind = frame_kind;

endmodule
